/* hw/rtl/flag_table_find_or_insert_macros.svh */
// Assertion macros for the find-or-insert flag table.
// Used by the top level; no other dependencies.
`ifndef FLAG_TABLE_FIND_OR_INSERT_MACROS_SVH
`define FLAG_TABLE_FIND_OR_INSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fti_pkg.sv */
// Package for the find-or-insert flag table: field widths, request codes,
// sequencer states and the store control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fti_pkg;

    localparam int HASH_W  = 15;
    localparam int WORD_W  = 16;
    localparam int KEY_W   = HASH_W + 2 * WORD_W;
    localparam int REQ_W   = 2;
    localparam int OUT_IDX_W = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_FIND  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Controls from the sequencer to the entry store.
    typedef struct packed {
        logic key_we;
        logic done_we;
        logic done_wdata;
        logic rd_en;
    } store_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/flag_table_find_or_insert.sv */
// Top level of the find-or-insert flag table: request sequencer, fill count
// and output register. Depends on fti_pkg, fti_store, fti_match and the macros.
//
//   Channel   Handshake             Word contents
//   in        in_valid / in_ready   req_type, name_hash, zone_number,
//                                   link_number, target_index, flag_value
//   out       out_valid / out_ready entry_index, done_flag, table_full
//
// A lookup scans the filled entries in order and stops at the first hit; a miss
// appends the key or reports the table full. The key store has one read port,
// so the scan reads and compares one filled entry per cycle. Set, clear and
// unused requests are answered without a scan.
// Reset empties the table at once through the fill count; no clearing pass.
// in_ready is low during a scan and while a result word waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "flag_table_find_or_insert_macros.svh"

module flag_table_find_or_insert #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fti_pkg::REQ_W-1:0]     req_type,
    input  wire logic [fti_pkg::HASH_W-1:0]    name_hash,
    input  wire logic [fti_pkg::WORD_W-1:0]    zone_number,
    input  wire logic [fti_pkg::WORD_W-1:0]    link_number,
    input  wire logic [7:0]                    target_index,
    input  wire logic                          flag_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [fti_pkg::OUT_IDX_W-1:0] entry_index,
    output logic                               done_flag,
    output logic                               table_full
);
    import fti_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int TGT_W = (CNT_W > 8) ? CNT_W : 8;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       filled_reg, filled_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic                   out_done_reg, out_done_next;
    logic                   out_full_reg, out_full_next;

    store_ctrl_t            st_ctrl;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic [KEY_W-1:0]       rd_key;
    logic                   rd_done;
    logic                   key_equal;
    logic                   in_take;
    logic                   tgt_in_range;

    fti_store #(
        .IDX_W(IDX_W)
    ) u_store (
        .clk     (clk),
        .ctrl    (st_ctrl),
        .wr_addr (wr_addr),
        .wr_key  (key_reg),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_done (rd_done)
    );

    fti_match u_match (
        .probe_key  (key_reg),
        .stored_key (rd_key),
        .key_equal  (key_equal)
    );

    // Accept only when idle and the output register is free by this edge.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_take  = in_valid && in_ready;
    assign tgt_in_range = (TGT_W'(target_index) < TGT_W'(TABLE_ENTRIES));

    // Request sequencer and scan.
    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_done_next  = out_done_reg;
        out_full_next  = out_full_reg;
        st_ctrl        = '0;
        wr_addr        = '0;
        rd_addr        = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (req_type)
                        REQ_FIND:
                        begin
                            key_next   = {name_hash, zone_number, link_number};
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        REQ_SET:
                        begin
                            st_ctrl.done_we    = tgt_in_range;
                            st_ctrl.done_wdata = flag_value;
                            wr_addr            = IDX_W'(target_index);
                            out_valid_next     = 1'b1;
                            out_idx_next       = target_index;
                            out_done_next      = flag_value;
                            out_full_next      = 1'b0;
                        end
                        REQ_CLEAR:
                        begin
                            filled_next    = '0;
                            out_valid_next = 1'b1;
                            out_idx_next   = '0;
                            out_done_next  = 1'b0;
                            out_full_next  = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_idx_next   = '0;
                            out_done_next  = 1'b0;
                            out_full_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && key_equal)
                begin
                    // Hit on the entry read in the previous cycle.
                    out_valid_next = 1'b1;
                    out_idx_next   = OUT_IDX_W'(pend_idx_reg);
                    out_done_next  = rd_done;
                    out_full_next  = 1'b0;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (idx_reg < filled_reg)
                begin
                    // Read the next filled entry.
                    st_ctrl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    // Every filled entry missed: append, or report full.
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_done_next  = 1'b0;
                    if (filled_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        out_idx_next  = '0;
                        out_full_next = 1'b1;
                    end
                    else
                    begin
                        st_ctrl.key_we     = 1'b1;
                        st_ctrl.done_we    = 1'b1;
                        st_ctrl.done_wdata = 1'b0;
                        wr_addr            = filled_reg[IDX_W-1:0];
                        filled_next        = filled_reg + CNT_W'(1);
                        out_idx_next       = OUT_IDX_W'(filled_reg);
                        out_full_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        out_idx_reg  <= out_idx_next;
        out_done_reg <= out_done_next;
        out_full_reg <= out_full_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_idx_reg;
    assign done_flag   = out_done_reg;
    assign table_full  = out_full_reg;

    // The fill count never passes the table size.
    `FTI_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, filled_reg <= CNT_W'(TABLE_ENTRIES), "fill count beyond table size")
    // No result word is pending while a scan runs.
    `FTI_ASSERT_SAME(a_scan_out_free, clk, rst_n, state_reg == ST_SCAN, !out_valid_reg, "result pending during scan")
    // The fill count only steps up by one or drops to zero.
    `FTI_ASSERT_NEXT(a_fill_step, clk, rst_n, 1'b1, (filled_reg == $past(filled_reg)) || (filled_reg == '0) || (filled_reg == $past(filled_reg) + CNT_W'(1)), "fill count jumped")

endmodule

`default_nettype wire

/* hw/rtl/fti_store.sv */
// Entry store of the flag table: key memory and done-bit memory with one
// write port and one registered read port. Depends on fti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fti_store #(
    parameter int IDX_W = 8
) (
    input  wire logic                      clk,
    input  wire fti_pkg::store_ctrl_t      ctrl,
    input  wire logic [IDX_W-1:0]          wr_addr,
    input  wire logic [fti_pkg::KEY_W-1:0] wr_key,
    input  wire logic [IDX_W-1:0]          rd_addr,
    output logic      [fti_pkg::KEY_W-1:0] rd_key,
    output logic                           rd_done
);
    import fti_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic             done_mem [DEPTH];
    logic [KEY_W-1:0] rd_key_reg;
    logic             rd_done_reg;

    // Write port: keys on insert, done bits on insert or set.
    always_ff @(posedge clk)
    begin
        if (ctrl.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctrl.done_we)
        begin
            done_mem[wr_addr] <= ctrl.done_wdata;
        end
    end

    // Registered read port, one entry per cycle during a scan.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_done_reg <= done_mem[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_done = rd_done_reg;

endmodule

`default_nettype wire

/* hw/rtl/fti_match.sv */
// Key comparator shared by every step of a lookup scan.
// Depends on fti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fti_match (
    input  wire logic [fti_pkg::KEY_W-1:0] probe_key,
    input  wire logic [fti_pkg::KEY_W-1:0] stored_key,
    output logic                           key_equal
);
    import fti_pkg::*;

    // Hash, zone and link must all agree.
    always_comb
    begin
        key_equal = (probe_key == stored_key);
    end

endmodule

`default_nettype wire
